FILE: rtl/elr_pkg.sv
package elr_pkg;

   localparam int EVENT_DEPTH_DEF = 256;
   localparam int EVENT_BITS_DEF  = 32;
   localparam int TIME_BITS_DEF   = 32;

   typedef enum logic [1:0] {
      MODE_STOPPED   = 2'd0,
      MODE_ARMED     = 2'd1,
      MODE_RECORDING = 2'd2,
      MODE_PLAYING   = 2'd3
   } mode_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_PLAY = 1'b1
   } fsm_type;

   // store port controls
   typedef struct packed {
      logic ev_we;
      logic tm_we;
      logic rd_en;
   } store_ctl_type;

endpackage

FILE: rtl/elr_store.sv
module elr_store import elr_pkg::*; #(
   parameter int EVENT_DEPTH = EVENT_DEPTH_DEF,
   parameter int EVENT_BITS  = EVENT_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF,
   localparam int ADDR_BITS  = $clog2(EVENT_DEPTH)
) (
   input  logic                   clock,
   input  store_ctl_type          ctl,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  logic [EVENT_BITS-1:0]  wr_event,
   input  logic [TIME_BITS-1:0]   wr_time,
   input  logic [ADDR_BITS-1:0]   rd_addr,
   output logic [EVENT_BITS-1:0]  rd_event,
   output logic [TIME_BITS-1:0]   rd_time
);

   // event words and their tick times, one entry per recorded word; the loop end marker adds a time-only entry
   logic [EVENT_BITS-1:0] ev_mem [EVENT_DEPTH];
   logic [TIME_BITS-1:0]  tm_mem [EVENT_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.ev_we) begin
         ev_mem[wr_addr] <= wr_event;
      end
      if (ctl.rd_en) begin
         rd_event <= ev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.tm_we) begin
         tm_mem[wr_addr] <= wr_time;
      end
      if (ctl.rd_en) begin
         rd_time <= tm_mem[rd_addr];
      end
   end

endmodule

FILE: rtl/event_loop_recorder.sv
// Event loop recorder. One request word is one tick of the loop clock.
// Request channel (req_*): record request update, play level, and an
// optional incoming event word. Response channel (rsp_*): at most one
// word per tick, either the incoming event passed through or a stored
// event played back, plus the mode after the tick and a store-full flag.
// Ticks that produce nothing (idle tick, armed without event, playing
// with nothing due) give no response word.
// Tick flow: in stopped, armed and recording modes a tick's response is
// registered at the same edge that takes the tick. A tick that ends in
// playing mode also passes through the play state: the event/time store
// read at the play pointer is registered, and the due-time compare is
// done on the registered read data, with no new tick taken meanwhile.
// Reset (synchronous, active high) returns to stopped with counters and
// loop length at zero; the stores are not cleared and need no clearing
// pass. Playback before any recording reads unwritten entries.
// Stalls: the response register holds one word; a new tick is taken
// only in the idle state, when that register is empty or is being drained
// in the same cycle, so a stalled receiver stops the request side after one word.
module event_loop_recorder import elr_pkg::*; #(
   parameter int EVENT_DEPTH = EVENT_DEPTH_DEF,
   parameter int EVENT_BITS  = EVENT_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_record_write,
   input  logic        req_record_value,
   input  logic        req_play_request,
   input  logic        req_event_valid,
   input  logic [31:0] req_event_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_event,
   output logic        rsp_from_playback,
   output logic [1:0]  rsp_mode_now,
   output logic        rsp_store_full
);

   localparam int ADDR_BITS = $clog2(EVENT_DEPTH);
   localparam int IDX_BITS  = $clog2(EVENT_DEPTH + 1);
   localparam logic [IDX_BITS-1:0] IDX_DEPTH = IDX_BITS'(EVENT_DEPTH);

   // control state
   fsm_type                 state_ff, state_in;
   mode_type                mode_ff, mode_in;
   logic                    rr_ff, rr_in;        // record request bit
   logic [IDX_BITS-1:0]     step_ff, step_in;    // record / play pointer
   logic [TIME_BITS-1:0]    tick_ff, tick_in;
   logic [TIME_BITS-1:0]    loop_ff, loop_in;
   logic [EVENT_BITS-1:0]   first_ev_ff, first_ev_in; // copy of entry 0

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_event_ff;
   logic                    rsp_pb_ff;
   mode_type                rsp_mode_ff;
   logic                    rsp_full_ff;

   // store interface
   store_ctl_type           ctl;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [EVENT_BITS-1:0]   wr_event;
   logic [TIME_BITS-1:0]    wr_time;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [EVENT_BITS-1:0]   rd_event;
   logic [TIME_BITS-1:0]    rd_time;

   // tick datapath
   logic                    req_accept;
   logic                    emit;
   logic [EVENT_BITS-1:0]   emit_event;
   logic                    emit_pb;
   logic                    emit_full;
   logic [EVENT_BITS-1:0]   ev_in;
   logic [TIME_BITS-1:0]    due;
   logic                    wrap;
   logic [IDX_BITS-1:0]     play_step;

   assign req_accept = req_valid & req_ready;
   assign ev_in      = EVENT_BITS'(req_event_word);

   elr_store #(
      .EVENT_DEPTH (EVENT_DEPTH),
      .EVENT_BITS  (EVENT_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_store (
      .clock    (clock),
      .ctl      (ctl),
      .wr_addr  (wr_addr),
      .wr_event (wr_event),
      .wr_time  (wr_time),
      .rd_addr  (rd_addr),
      .rd_event (rd_event),
      .rd_time  (rd_time)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_accept && mode_in == MODE_PLAYING) begin
               state_in = FSM_PLAY;
            end
         end
         FSM_PLAY: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // FSM outputs: take a tick only when the response slot is free or draining
   always_comb begin
      case (state_ff)
         FSM_IDLE: req_ready = !rsp_valid_ff || rsp_ready;
         FSM_PLAY: req_ready = 1'b0;
         default:  req_ready = 1'b0;
      endcase
   end

   // tick processing
   always_comb begin
      mode_in     = mode_ff;
      rr_in       = rr_ff;
      step_in     = step_ff;
      tick_in     = tick_ff;
      loop_in     = loop_ff;
      first_ev_in = first_ev_ff;
      emit        = 1'b0;
      emit_event  = '0;
      emit_pb     = 1'b0;
      emit_full   = 1'b0;
      ctl         = '0;
      wr_addr     = '0;
      wr_event    = ev_in;
      wr_time     = '0;
      rd_addr     = '0;
      due         = '0;
      wrap        = 1'b0;
      play_step   = '0;
      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               tick_in = tick_ff + TIME_BITS'(1);
               if (req_record_write) begin
                  rr_in = req_record_value;
               end
               // mode transitions
               case (mode_ff)
                  MODE_STOPPED: begin
                     if (rr_in) begin
                        mode_in = MODE_ARMED;
                     end
                     if (req_play_request) begin
                        mode_in = MODE_PLAYING;
                        step_in = '0;
                     end
                  end
                  MODE_ARMED: begin
                     if (!rr_in) begin
                        mode_in = MODE_STOPPED;
                     end
                  end
                  MODE_RECORDING: begin
                     if (req_play_request) begin
                        // close the loop: end marker carries the loop length
                        mode_in     = MODE_PLAYING;
                        ctl.tm_we   = step_ff < IDX_DEPTH;
                        wr_addr     = step_ff[ADDR_BITS-1:0];
                        wr_time     = tick_in;
                        loop_in     = tick_in;
                        rr_in       = 1'b0;
                        step_in     = '0;
                        tick_in     = '0;
                     end
                  end
                  default: begin
                     if (!req_play_request) begin
                        mode_in = MODE_STOPPED;
                     end
                  end
               endcase
               // mode action
               case (mode_in)
                  MODE_STOPPED: begin
                     emit       = req_event_valid;
                     emit_event = ev_in;
                  end
                  MODE_ARMED: begin
                     if (req_event_valid) begin
                        // first event starts the loop at time zero
                        mode_in     = MODE_RECORDING;
                        ctl.ev_we   = 1'b1;
                        ctl.tm_we   = 1'b1;
                        wr_addr     = '0;
                        wr_time     = '0;
                        first_ev_in = ev_in;
                        tick_in     = '0;
                        step_in     = IDX_BITS'(1);
                        emit        = 1'b1;
                        emit_event  = ev_in;
                     end
                  end
                  MODE_RECORDING: begin
                     if (req_event_valid) begin
                        emit       = 1'b1;
                        emit_event = ev_in;
                        if (step_in < IDX_DEPTH) begin
                           ctl.ev_we = 1'b1;
                           ctl.tm_we = 1'b1;
                           wr_addr   = step_in[ADDR_BITS-1:0];
                           wr_time   = tick_in;
                           loop_in   = tick_in;
                           step_in   = step_in + IDX_BITS'(1);
                        end else begin
                           emit_full = 1'b1;
                        end
                     end
                  end
                  default: begin
                     // fetch the entry at the play pointer
                     ctl.rd_en = 1'b1;
                     rd_addr   = step_in[ADDR_BITS-1:0];
                  end
               endcase
            end
         end
         FSM_PLAY: begin
            due = (step_ff < IDX_DEPTH) ? rd_time : loop_ff;
            if (tick_ff >= due) begin
               wrap      = tick_ff >= loop_ff;
               play_step = wrap ? '0 : step_ff;
               if (wrap) begin
                  tick_in = '0;
               end
               step_in = play_step;
               if (play_step < IDX_DEPTH) begin
                  emit       = 1'b1;
                  emit_pb    = 1'b1;
                  emit_event = wrap ? first_ev_ff : rd_event;
                  step_in    = play_step + IDX_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         mode_ff      <= MODE_STOPPED;
         rr_ff        <= 1'b0;
         step_ff      <= '0;
         tick_ff      <= '0;
         loop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rr_ff        <= rr_in;
         step_ff      <= step_in;
         tick_ff      <= tick_in;
         loop_ff      <= loop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ev_ff <= first_ev_in;
      if (emit) begin
         rsp_event_ff <= 32'(emit_event);
         rsp_pb_ff    <= emit_pb;
         rsp_mode_ff  <= mode_in;
         rsp_full_ff  <= emit_full;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_event     = rsp_event_ff;
   assign rsp_from_playback = rsp_pb_ff;
   assign rsp_mode_now      = rsp_mode_ff;
   assign rsp_store_full    = rsp_full_ff;

`ifndef ASSERT_OFF
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= IDX_DEPTH)
      else $error("play/record pointer beyond store depth");

   a_play_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_PLAY |-> !req_ready && mode_ff == MODE_PLAYING)
      else $error("tick taken during playback compare");

   a_full_recording: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_full_ff |-> rsp_mode_ff == MODE_RECORDING && !rsp_pb_ff)
      else $error("store full flagged outside recording");

   a_pb_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pb_ff |-> rsp_mode_ff == MODE_PLAYING)
      else $error("playback word outside playing mode");

   a_play_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_PLAY |-> $past(ctl.rd_en))
      else $error("playback compare without store read");
`endif

endmodule
